FILE: rtl/cdbd_pkg.sv
package cdbd_pkg;

  localparam int MAX_WIDTH_DEF = 2048;
  localparam int DIM_W         = 12;
  localparam int CFG_AW        = 4;
  localparam int CFG_DW        = 32;

  localparam logic [1:0]       COLOR_BLUE = 2'd0;
  localparam logic [1:0]       COLOR_RED  = 2'd2;

  localparam logic             ACT_PIXEL = 1'b0;
  localparam logic             ACT_DRAIN = 1'b1;

  localparam logic [1:0]       ENEMY_COLOR_RST  = COLOR_BLUE;
  localparam logic [7:0]       DIFF_LEVEL_RST   = 8'd100;
  localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 12'd640;
  localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 12'd480;

  typedef enum logic [1:0] {
    REG_ENEMY_COLOR  = 2'd0,
    REG_DIFF_LEVEL   = 2'd1,
    REG_FRAME_WIDTH  = 2'd2,
    REG_FRAME_HEIGHT = 2'd3
  } cfg_reg_e_t;

  typedef struct packed {
    logic [1:0]       enemy_color;
    logic [7:0]       diff_level;
    logic [DIM_W-1:0] frame_width;
    logic [DIM_W-1:0] frame_height;
  } cfg_t;

  typedef struct packed {
    logic       action;
    logic [7:0] blue;
    logic [7:0] red;
  } in_item_t;

  typedef struct packed {
    logic mask;
    logic last;
  } out_item_t;

  function automatic logic classify(input logic [1:0] enemy_color,
                                    input logic [7:0] threshold,
                                    input logic [7:0] blue,
                                    input logic [7:0] red);
    logic signed [8:0] r_minus_b;
    logic signed [8:0] b_minus_r;
    logic signed [8:0] thr;
    logic              hit;
    r_minus_b = $signed({1'b0, red}) - $signed({1'b0, blue});
    b_minus_r = $signed({1'b0, blue}) - $signed({1'b0, red});
    thr       = $signed({1'b0, threshold});
    case (enemy_color)
      COLOR_RED:  hit = (r_minus_b > thr);
      COLOR_BLUE: hit = (b_minus_r > thr);
      default:    hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

FILE: rtl/cdbd_cfg.sv
module cdbd_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [cdbd_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [cdbd_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [cdbd_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready,
  output cdbd_pkg::cfg_t                cfg,
  output cdbd_pkg::cfg_t                cfg_nxt
);

  cdbd_pkg::cfg_t       cfg_r;
  cdbd_pkg::cfg_reg_e_t reg_idx;
  logic                 wr_en;

  assign reg_idx    = cdbd_pkg::cfg_reg_e_t'(cfg_paddr[cdbd_pkg::CFG_AW-1:2]);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        cdbd_pkg::REG_ENEMY_COLOR: cfg_nxt.enemy_color = cfg_pwdata[1:0];
        cdbd_pkg::REG_DIFF_LEVEL:  cfg_nxt.diff_level  = cfg_pwdata[7:0];
        cdbd_pkg::REG_FRAME_WIDTH:
          cfg_nxt.frame_width = cfg_pwdata[cdbd_pkg::DIM_W-1:0];
        cdbd_pkg::REG_FRAME_HEIGHT:
          cfg_nxt.frame_height = cfg_pwdata[cdbd_pkg::DIM_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      cdbd_pkg::REG_ENEMY_COLOR:  cfg_prdata = cdbd_pkg::CFG_DW'(cfg_r.enemy_color);
      cdbd_pkg::REG_DIFF_LEVEL:   cfg_prdata = cdbd_pkg::CFG_DW'(cfg_r.diff_level);
      cdbd_pkg::REG_FRAME_WIDTH:  cfg_prdata = cdbd_pkg::CFG_DW'(cfg_r.frame_width);
      cdbd_pkg::REG_FRAME_HEIGHT: cfg_prdata = cdbd_pkg::CFG_DW'(cfg_r.frame_height);
      default:                    cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enemy_color  <= cdbd_pkg::ENEMY_COLOR_RST;
      cfg_r.diff_level   <= cdbd_pkg::DIFF_LEVEL_RST;
      cfg_r.frame_width  <= cdbd_pkg::FRAME_WIDTH_RST;
      cfg_r.frame_height <= cdbd_pkg::FRAME_HEIGHT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: rtl/cdbd_core.sv
module cdbd_core #(
  parameter int MAX_WIDTH = cdbd_pkg::MAX_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cdbd_pkg::cfg_t      cfg,
  input  cdbd_pkg::cfg_t      cfg_nxt,
  input  logic                in_valid,
  output logic                in_stall,
  input  cdbd_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output cdbd_pkg::out_item_t out_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int DW = cdbd_pkg::DIM_W;

  function automatic logic [WW-1:0] eff_w(input logic [DW-1:0] fw);
    logic [WW-1:0] w;
    if (fw == '0) begin
      w = WW'(1);
    end else if (32'(fw) > 32'(MAX_WIDTH)) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = WW'(fw);
    end
    return w;
  endfunction

  function automatic logic [DW-1:0] eff_h(input logic [DW-1:0] fh);
    return (fh == '0) ? DW'(1) : fh;
  endfunction

  // line store: bit 1 older row, bit 0 most recent row
  logic [1:0]          store_mem [MAX_WIDTH];

  logic [CW-1:0]       col_r, col_nxt, col_s;
  logic [DW-1:0]       row_r, row_nxt, row_s;
  logic                left_r, left_nxt, left_s;
  logic                mid_r, older_r, right_r;
  logic                out_valid_r;
  cdbd_pkg::out_item_t out_data_r;

  logic [WW-1:0]       w, w_n, c1;
  logic [DW-1:0]       h, h_n;
  logic                drain, acc, step, emit, cur, above_ok, right_ok;
  logic                left, res, last, wrap;
  logic [CW-1:0]       rd_a, rd_b;
  logic [1:0]          wr_d;

  assign w        = eff_w(cfg.frame_width);
  assign h        = eff_h(cfg.frame_height);
  assign drain    = (row_r == h);
  assign in_stall = out_valid_r && out_stall;
  assign acc      = in_valid && !in_stall;
  assign step     = acc && (drain || in_data.action == cdbd_pkg::ACT_PIXEL);

  assign cur = drain ? 1'b0 :
               cdbd_pkg::classify(cfg.enemy_color, cfg.diff_level,
                                  in_data.blue, in_data.red);

  assign above_ok = drain ? (h >= DW'(2)) : (row_r >= DW'(2));
  assign c1       = WW'(col_r) + WW'(1);
  assign right_ok = (c1 < w);
  assign left     = (col_r == '0) ? 1'b0 : left_r;
  assign res      = mid_r | (above_ok & older_r) | (right_ok & right_r) | left | cur;
  assign emit     = step && (drain || row_r != '0);
  assign last     = drain && (c1 == w);
  assign wr_d     = {mid_r, cur};

  always_comb begin
    col_s  = col_r;
    row_s  = row_r;
    left_s = left_r;
    if (step) begin
      left_s = mid_r;
      if (c1 >= w) begin
        col_s = '0;
        row_s = drain ? '0 : row_r + DW'(1);
      end else begin
        col_s = CW'(c1);
      end
    end
  end

  // geometry change can leave the counts out of range: restart the frame
  assign w_n      = eff_w(cfg_nxt.frame_width);
  assign h_n      = eff_h(cfg_nxt.frame_height);
  assign wrap     = (WW'(col_s) >= w_n) || (row_s > h_n);
  assign col_nxt  = wrap ? '0 : col_s;
  assign row_nxt  = wrap ? '0 : row_s;
  assign left_nxt = wrap ? 1'b0 : left_s;

  // prefetch for the next column
  assign rd_a = col_nxt;
  assign rd_b = (col_nxt == CW'(MAX_WIDTH - 1)) ? '0 : col_nxt + CW'(1);

  always_ff @(posedge clk) begin
    if (step) begin
      store_mem[col_r] <= wr_d;
    end
    if (step && col_r == rd_a) begin
      {older_r, mid_r} <= wr_d;
    end else begin
      {older_r, mid_r} <= store_mem[rd_a];
    end
    if (step && col_r == rd_b) begin
      right_r <= cur;
    end else begin
      right_r <= store_mem[rd_b][0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      left_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      left_r <= left_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r.mask <= res;
      out_data_r.last <= last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: rtl/color_difference_binarize_dilate.sv
// channel  direction  payload              request taken when
// in_      input      cdbd_pkg::in_item_t  in_valid & !in_stall
// out_     output     cdbd_pkg::out_item_t out_valid & !out_stall
// cfg_     input      apb, 4 x 32-bit regs psel & penable & pwrite
//
// one request per cycle unless in_stall; a registered result follows in the next cycle
// line store read is prefetched for the next column, so no bubbles between requests
// in_stall is high only while a result is held and out_stall is high
// rst_n is synchronous; the line stores are not cleared, the first row of a frame fills them
module color_difference_binarize_dilate #(
  parameter int MAX_WIDTH = cdbd_pkg::MAX_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  cdbd_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output cdbd_pkg::out_item_t         out_data,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [cdbd_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [cdbd_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [cdbd_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                        cfg_pready
);

  cdbd_pkg::cfg_t cfg;
  cdbd_pkg::cfg_t cfg_nxt;

  cdbd_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg),
    .cfg_nxt     (cfg_nxt)
  );

  cdbd_core #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cfg_nxt   (cfg_nxt),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
